// File: rtl/core/brfb_pkg.sv
// brfb_pkg: shared widths, opcodes, status codes and register indexes
// for the byte ring FIFO. No dependencies.
package brfb_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 8;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 4;
  localparam int DATA_W = 64;
  localparam int ST_W   = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_ELEMS = 2'd3;

  // configuration register indexes (byte address = 4 * index)
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_OVERWRITE    = 2'd0;
  localparam logic [1:0] REG_PARTIAL_PUSH = 2'd1;
  localparam logic [1:0] REG_PARTIAL_TAKE = 2'd2;

  typedef struct packed {
    logic overwrite_enable;
    logic partial_push_enable;
    logic partial_take_enable;
  } cfg_t;

endpackage

// File: rtl/core/brfb_store.sv
// brfb_store: byte store of the ring FIFO, one write and one read port,
// registered read data. Depends on nothing.
module brfb_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/brfb_ctrl.sv
// brfb_ctrl: request sequencer of the ring FIFO. Holds pointers and count,
// moves one byte a cycle through the store and keeps the result register.
// Depends on brfb_pkg.
module brfb_ctrl #(
  parameter int DEPTH     = brfb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brfb_pkg::MAX_BURST_DEF,
  parameter int AW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brfb_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brfb_pkg::OP_W-1:0]     in_opcode,
  input  logic [brfb_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [brfb_pkg::DATA_W-1:0]   in_push_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brfb_pkg::ST_W-1:0]     out_status,
  output logic [brfb_pkg::SIZE_W-1:0]   out_moved_count,
  output logic [brfb_pkg::DATA_W-1:0]   out_taken_bytes,
  output logic [CW-1:0]                 out_fill_level,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [7:0]                    mem_rdata
);

  localparam int SW = brfb_pkg::SIZE_W;
  localparam int DW = brfb_pkg::DATA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_TAKE  = 3'd2;
  localparam logic [2:0] S_TLAST = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [AW-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]            held_r, held_nxt;
  logic [SW-1:0]            cnt_r, cnt_nxt;
  logic [SW-1:0]            n_r, n_nxt;
  logic [DW-1:0]            data_r, data_nxt;
  logic [DW-1:0]            acc_r, acc_nxt;
  logic                     rvalid_r, rvalid_nxt;
  logic [2:0]               rslot_r, rslot_nxt;
  logic [brfb_pkg::ST_W-1:0] res_status_r, res_status_nxt;
  logic [SW-1:0]            res_moved_r, res_moved_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [brfb_pkg::ST_W-1:0] out_status_r;
  logic [SW-1:0]            out_moved_r;
  logic [DW-1:0]            out_taken_r;
  logic [CW-1:0]            out_fill_r;

  logic                     accept;
  logic                     last;
  logic                     size_ok;
  logic [CW-1:0]            space;
  logic [CW-1:0]            size_ext;
  logic [CW:0]              push_sum;
  logic                     slot_free;
  logic                     load_out;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos);
    if (pos == AW'(DEPTH - 1)) begin
      return '0;
    end
    return pos + 1'b1;
  endfunction

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign last      = ({1'b0, cnt_r} + 1'b1) == {1'b0, n_r};
  assign size_ok   = (in_request_size != '0) && (in_request_size <= SW'(MAX_BURST));
  assign space     = CW'(DEPTH) - held_r;
  assign size_ext  = CW'(in_request_size);
  assign push_sum  = {1'b0, held_r} + (CW + 1)'(n_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == S_DONE) && slot_free;

  always_comb begin
    state_nxt      = state_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    held_nxt       = held_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    data_nxt       = data_r;
    acc_nxt        = acc_r;
    rvalid_nxt     = 1'b0;
    rslot_nxt      = rslot_r;
    res_status_nxt = res_status_r;
    res_moved_nxt  = res_moved_r;

    // read data lands in the cycle after the address
    if (rvalid_r) begin
      acc_nxt[rslot_r * 8 +: 8] = mem_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt        = '0;
          data_nxt       = in_push_bytes;
          acc_nxt        = '0;
          res_status_nxt = brfb_pkg::ST_OK;
          res_moved_nxt  = '0;
          state_nxt      = S_DONE;
          case (in_opcode)
            brfb_pkg::OP_PUSH: begin
              if (!size_ok) begin
                res_status_nxt = brfb_pkg::ST_RANGE;
              end else if (size_ext <= space) begin
                n_nxt     = in_request_size;
                state_nxt = S_PUSH;
              end else if (cfg.overwrite_enable) begin
                n_nxt     = in_request_size;
                state_nxt = S_PUSH;
              end else if (cfg.partial_push_enable && (space != '0)) begin
                n_nxt     = space[SW-1:0];
                state_nxt = S_PUSH;
              end else begin
                res_status_nxt = brfb_pkg::ST_NO_SPACE;
              end
            end
            brfb_pkg::OP_TAKE: begin
              if (!size_ok) begin
                res_status_nxt = brfb_pkg::ST_RANGE;
              end else if (size_ext <= held_r) begin
                n_nxt     = in_request_size;
                state_nxt = S_TAKE;
              end else if (cfg.partial_take_enable && (held_r != '0)) begin
                n_nxt     = held_r[SW-1:0];
                state_nxt = S_TAKE;
              end else begin
                res_status_nxt = brfb_pkg::ST_NO_ELEMS;
              end
            end
            brfb_pkg::OP_FLUSH: begin
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              held_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH: begin
        data_nxt   = data_r >> 8;
        wr_ptr_nxt = advance(wr_ptr_r);
        cnt_nxt    = cnt_r + 1'b1;
        if (last) begin
          res_moved_nxt = n_r;
          // overwrite leaves the store full with read pointer on write pointer
          if (push_sum >= (CW + 1)'(DEPTH)) begin
            held_nxt   = CW'(DEPTH);
            rd_ptr_nxt = advance(wr_ptr_r);
          end else begin
            held_nxt = push_sum[CW-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_TAKE: begin
        rvalid_nxt = 1'b1;
        rslot_nxt  = cnt_r[2:0];
        rd_ptr_nxt = advance(rd_ptr_r);
        cnt_nxt    = cnt_r + 1'b1;
        if (last) begin
          res_moved_nxt = n_r;
          held_nxt      = held_r - CW'(n_r);
          state_nxt     = S_TLAST;
        end
      end
      S_TLAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      held_r      <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      held_r      <= held_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    n_r          <= n_nxt;
    data_r       <= data_nxt;
    acc_r        <= acc_nxt;
    rslot_r      <= rslot_nxt;
    res_status_r <= res_status_nxt;
    res_moved_r  <= res_moved_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_moved_r  <= res_moved_r;
      out_taken_r  <= acc_r;
      out_fill_r   <= held_r;
    end
  end

  assign mem_we    = (state_r == S_PUSH);
  assign mem_waddr = wr_ptr_r;
  assign mem_wdata = data_r[7:0];
  assign mem_re    = (state_r == S_TAKE);
  assign mem_raddr = rd_ptr_r;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_moved_count = out_moved_r;
  assign out_taken_bytes = out_taken_r;
  assign out_fill_level  = out_fill_r;

endmodule

// File: rtl/core/byte_ring_fifo_burst.sv
// byte_ring_fifo_burst: top level of the burst byte ring FIFO with its
// configuration registers. Depends on brfb_pkg, brfb_store and brfb_ctrl.
//
// Byte FIFO of DEPTH entries taking push, take, flush and query requests,
// one result per request. Requests are handled one at a time and bytes move
// one per cycle through the byte store: a push passes the push state once
// per byte, a take the take state once per byte and then a last state for
// the store's read latency, and both end in the done state, as do a flush,
// query or refused request. The result sits in an output register, so the
// next request is taken while a result waits; the block only holds in its
// done state while it is full and stalled. Configuration lives at byte
// addresses 0 (overwrite), 4 (partial push) and 8 (partial take), bit 0.
module byte_ring_fifo_burst #(
  parameter int DEPTH     = brfb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brfb_pkg::MAX_BURST_DEF,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brfb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brfb_pkg::OP_W-1:0]     in_opcode,
  input  logic [brfb_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [brfb_pkg::DATA_W-1:0]   in_push_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brfb_pkg::ST_W-1:0]     out_status,
  output logic [brfb_pkg::SIZE_W-1:0]   out_moved_count,
  output logic [brfb_pkg::DATA_W-1:0]   out_taken_bytes,
  output logic [CW-1:0]                 out_fill_level
);

  localparam int AW = $clog2(DEPTH);

  brfb_pkg::cfg_t cfg_r, cfg_nxt;
  logic [1:0]     reg_idx;
  logic           cfg_wr;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        brfb_pkg::REG_OVERWRITE:    cfg_nxt.overwrite_enable    = pwdata[0];
        brfb_pkg::REG_PARTIAL_PUSH: cfg_nxt.partial_push_enable = pwdata[0];
        brfb_pkg::REG_PARTIAL_TAKE: cfg_nxt.partial_take_enable = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      brfb_pkg::REG_OVERWRITE:    prdata[0] = cfg_r.overwrite_enable;
      brfb_pkg::REG_PARTIAL_PUSH: prdata[0] = cfg_r.partial_push_enable;
      brfb_pkg::REG_PARTIAL_TAKE: prdata[0] = cfg_r.partial_take_enable;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  brfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brfb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_push_bytes   (in_push_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_moved_count (out_moved_count),
    .out_taken_bytes (out_taken_bytes),
    .out_fill_level  (out_fill_level),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule
